[design/fsif_pkg.sv]
// shared types, character codes and helpers for the integer formatter
package fsif_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_SIGN,
        ST_CONV,
        ST_DIGITS
    } t_state;

    localparam int FMT_W   = 8;
    localparam int FIELD_W = 32;
    localparam int S_DATA_W = FMT_W + FIELD_W;
    localparam int M_DATA_W = FMT_W + FIELD_W;

    localparam logic [FMT_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [FMT_W-1:0] CH_D       = 8'h64;
    localparam logic [FMT_W-1:0] CH_X       = 8'h78;
    localparam logic [FMT_W-1:0] CH_S       = 8'h73;
    localparam logic [FMT_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [FMT_W-1:0] CH_A       = 8'h61;
    localparam logic [FMT_W-1:0] CH_MINUS   = 8'h2d;

    localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

    // one hex or decimal digit to its ascii character
    function automatic logic [FMT_W-1:0] digit_char(input logic [3:0] d);
        logic [FMT_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + FMT_W'(d);
        end else begin
            c = CH_A + FMT_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

[design/format_string_integer_formatter.sv]
// printf-subset formatter: echoes format bytes and expands %d, %x and %%
//
// Takes one format byte per slave beat with its argument; gives one character per master
// beat with a saturating running count. An ordinary byte passes through the echo state to
// the output register; %x goes straight to the digit-serial output shifter; %d goes through
// a sign state when negative, then the bit-serial binary to bcd shift register, then the
// digit-serial output shifter. A new byte is taken once the previous one has handed all its
// characters to the output register, and master-side stalls hold the echo, sign and digit
// states. A leading '%' and "%s" give no beats.
module format_string_integer_formatter #(
    parameter int ARG_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [7:0] fmt_char, [39:8] arg_value
    input  logic [fsif_pkg::S_DATA_W-1:0] i_s_tdata,
    // [0] start_string
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] out_char, [39:8] char_count
    output logic [fsif_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast
);
    import fsif_pkg::*;

    localparam int HEX_DIGITS = (ARG_BITS + 3) / 4;
    localparam int HEX_W      = HEX_DIGITS * 4;
    localparam int DEC_DIGITS = (ARG_BITS * 30103) / 100000 + 1;
    localparam int DIG_W      = DEC_DIGITS * 4;
    localparam int HEX_SHIFT  = DIG_W - HEX_W;
    localparam int BIT_CNT_W  = $clog2(ARG_BITS + 1);
    localparam int LEFT_W     = $clog2(DEC_DIGITS + 1);

    t_state               r_state, n_state;
    logic                 r_pending, n_pending;
    logic [FIELD_W-1:0]   r_count, n_count;
    logic [FMT_W-1:0]     r_char, n_char;
    logic [ARG_BITS-1:0]  r_work, n_work;
    logic [DIG_W-1:0]     r_digits, n_digits;
    logic [BIT_CNT_W-1:0] r_bitcnt, n_bitcnt;
    logic [LEFT_W-1:0]    r_left, n_left;
    logic                 r_seen, n_seen;
    logic                 r_out_valid, n_out_valid;
    logic [FMT_W-1:0]     r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;
    logic [FIELD_W-1:0]   r_out_count, n_out_count;

    logic [FMT_W-1:0]     w_fmt;
    logic [ARG_BITS-1:0]  w_arg;
    logic [ARG_BITS-1:0]  w_mag;
    logic                 w_neg;
    logic                 w_accept;
    logic                 w_pend;
    logic                 w_slot;
    logic [FIELD_W-1:0]   w_count_base;
    logic [FIELD_W-1:0]   w_count_inc;
    logic [3:0]           w_top;
    logic                 w_visible;
    logic [DIG_W-1:0]     w_adj;

    assign w_fmt    = i_s_tdata[FMT_W-1:0];
    assign w_arg    = ARG_BITS'(i_s_tdata[S_DATA_W-1:FMT_W]);
    assign w_neg    = w_arg[ARG_BITS-1];
    assign w_mag    = w_neg ? (~w_arg + ARG_BITS'(1)) : w_arg;
    assign w_accept = i_s_tvalid && (r_state == ST_IDLE);
    assign w_pend   = i_s_tuser ? 1'b0 : r_pending;
    assign w_slot   = !r_out_valid || i_m_tready;

    assign w_count_base = r_count;
    assign w_count_inc  = (w_count_base == COUNT_MAX) ? w_count_base
                                                      : w_count_base + FIELD_W'(1);

    assign w_top     = r_digits[DIG_W-1 -: 4];
    assign w_visible = r_seen || (w_top != 4'd0) || (r_left == LEFT_W'(1));

    // add-three correction on every bcd digit before the shift
    always_comb begin
        logic [3:0] v_nib;
        w_adj = '0;
        for (int k = 0; k < DEC_DIGITS; k++) begin
            v_nib = r_digits[4*k +: 4];
            w_adj[4*k +: 4] = (v_nib >= 4'd5) ? v_nib + 4'd3 : v_nib;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_pend) begin
                        if (w_fmt == CH_S) begin
                            n_state = ST_IDLE;
                        end else if (w_fmt == CH_D) begin
                            n_state = w_neg ? ST_SIGN : ST_CONV;
                        end else if (w_fmt == CH_X) begin
                            n_state = ST_DIGITS;
                        end else begin
                            n_state = ST_ECHO;
                        end
                    end else if (w_fmt != CH_PERCENT) begin
                        n_state = ST_ECHO;
                    end
                end
            end
            ST_ECHO: begin
                if (w_slot) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SIGN: begin
                if (w_slot) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_bitcnt == BIT_CNT_W'(1)) begin
                    n_state = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (w_slot && (r_left == LEFT_W'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and output beat
    always_comb begin
        n_pending   = r_pending;
        n_count     = r_count;
        n_char      = r_char;
        n_work      = r_work;
        n_digits    = r_digits;
        n_bitcnt    = r_bitcnt;
        n_left      = r_left;
        n_seen      = r_seen;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_count = r_out_count;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser) begin
                        n_count = '0;
                    end
                    n_pending = !w_pend && (w_fmt == CH_PERCENT);
                    n_char    = w_fmt;
                    n_bitcnt  = BIT_CNT_W'(ARG_BITS);
                    n_seen    = 1'b0;
                    if (w_fmt == CH_X) begin
                        n_work   = w_arg;
                        n_digits = DIG_W'(HEX_W'(w_arg)) << HEX_SHIFT;
                        n_left   = LEFT_W'(HEX_DIGITS);
                    end else begin
                        n_work   = w_mag;
                        n_digits = '0;
                        n_left   = LEFT_W'(DEC_DIGITS);
                    end
                end
            end
            ST_ECHO: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_char;
                    n_out_last  = 1'b1;
                    n_out_count = w_count_inc;
                    n_count     = w_count_inc;
                end
            end
            ST_SIGN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_MINUS;
                    n_out_last  = 1'b0;
                    n_out_count = w_count_inc;
                    n_count     = w_count_inc;
                end
            end
            ST_CONV: begin
                n_digits = {w_adj[DIG_W-2:0], r_work[ARG_BITS-1]};
                n_work   = r_work << 1;
                n_bitcnt = r_bitcnt - BIT_CNT_W'(1);
            end
            ST_DIGITS: begin
                if (w_slot) begin
                    n_digits = r_digits << 4;
                    n_left   = r_left - LEFT_W'(1);
                    // leading zeros are dropped without a beat
                    if (w_visible) begin
                        n_seen      = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_char  = digit_char(w_top);
                        n_out_last  = (r_left == LEFT_W'(1));
                        n_out_count = w_count_inc;
                        n_count     = w_count_inc;
                    end
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pending   <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char      <= n_char;
        r_work      <= n_work;
        r_digits    <= n_digits;
        r_bitcnt    <= n_bitcnt;
        r_left      <= n_left;
        r_seen      <= n_seen;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_count <= n_out_count;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_count, r_out_char};
    assign o_m_tlast  = r_out_last;

endmodule

[tb/tb_top.sv]
// self-checking testbench for the printf-subset integer formatter
module tb_top;
    import fsif_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_BYTES = 345;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic [31:0] count;
    } t_emitted_char;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;
    logic                i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                o_m_tlast;

    // predictor state
    logic          pend_pct;
    logic [31:0]   char_total;
    t_emitted_char expected_chars[$];

    t_emitted_char want;
    t_emitted_char got;
    int            mismatches;
    int            bytes_sent;
    int            chars_checked;
    int            conversions;
    int            idle_cycles;
    int            stall_left;
    bit            quiet;

    format_string_integer_formatter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void emit_char(input logic [7:0] ch);
        if (char_total != '1) begin
            char_total = char_total + 1;
        end
        expected_chars.push_back('{ch, 1'b0, char_total});
    endfunction

    // most significant digit first, no leading zeros
    function automatic void emit_number(input logic [31:0] value, input bit hex);
        logic [3:0]  dig [0:10];
        logic [31:0] v;
        logic [31:0] base;
        int          n;
        base = hex ? 32'd16 : 32'd10;
        v = value;
        n = 0;
        do begin
            dig[n] = 4'(v % base);
            v = v / base;
            n++;
        end while (v != 0);
        for (int k = n - 1; k >= 0; k--) begin
            if (dig[k] < 4'd10) begin
                emit_char(8'(CH_ZERO + dig[k]));
            end else begin
                emit_char(8'(CH_A + (dig[k] - 4'd10)));
            end
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] ch, input logic [31:0] arg,
                                         input logic start);
        int n_before;
        n_before = expected_chars.size();
        if (start) begin
            char_total = '0;
            pend_pct = 1'b0;
        end
        if (pend_pct) begin
            pend_pct = 1'b0;
            if (ch == CH_PERCENT) begin
                emit_char(CH_PERCENT);
            end else if (ch == CH_S) begin
                // string expansion unsupported: nothing out
            end else if (ch == CH_D) begin
                conversions++;
                if (arg[31]) begin
                    emit_char(CH_MINUS);
                    emit_number(-arg, 1'b0);
                end else begin
                    emit_number(arg, 1'b0);
                end
            end else if (ch == CH_X) begin
                conversions++;
                emit_number(arg, 1'b1);
            end else begin
                // unknown conversion: the percent is dropped
                emit_char(ch);
            end
        end else if (ch == CH_PERCENT) begin
            pend_pct = 1'b1;
        end else begin
            emit_char(ch);
        end
        if (expected_chars.size() > n_before) begin
            expected_chars[$].last = 1'b1;
        end
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_arg();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 99);
            1: return -$urandom_range(1, 99);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'h8000_0000;
                    2: return 32'h7fff_ffff;
                    default: return 32'hffff_ffff;
                endcase
            end
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic [31:0] arg, input logic start);
        int gap;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = {arg, ch};
        i_s_tuser  = start;
        do @(posedge i_clk); while (!o_s_tready);
        predict_byte(ch, arg, start);
        bytes_sent++;
        gap = (quiet || $urandom_range(0, 99) < 50) ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            i_s_tdata  = {$urandom, 8'($urandom)};
            i_s_tuser  = 1'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_conv(input logic [7:0] conv, input logic [31:0] arg);
        send_byte(CH_PERCENT, rand_arg(), 1'b0);
        send_byte(conv, arg, 1'b0);
    endtask

    // receiver back-pressure: streaks of ready with short and long stalls
    initial begin
        i_m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_m_tready = 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 99) < 25) begin
                i_m_tready = 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[7:0], o_m_tlast, o_m_tdata[39:8]};
            chars_checked++;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected char %h last %b count %0d",
                             got.ch, got.last, got.count);
                end
            end else begin
                want = expected_chars.pop_front();
                if (got.ch !== want.ch || got.last !== want.last
                        || got.count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch char/last/count: expected %h/%b/%0d, got %h/%b/%0d",
                                 want.ch, want.last, want.count,
                                 got.ch, got.last, got.count);
                    end
                end
            end
        end
    end

    // watchdog on beats in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    task automatic test_echo();
        send_byte(8'h00, rand_arg(), 1'b1);
        send_byte(8'hff, rand_arg(), 1'b0);
    endtask

    task automatic test_percent_forms();
        send_conv(CH_PERCENT, rand_arg());
        send_conv(CH_S, rand_arg());
        send_conv(8'h71, rand_arg());
    endtask

    task automatic test_decimal();
        send_conv(CH_D, 32'h0000_0000);
        send_conv(CH_D, 32'hffff_ffff);
        send_conv(CH_D, 32'h8000_0000);
        send_conv(CH_D, 32'h7fff_ffff);
        send_conv(CH_D, -32'sd1000000000);
    endtask

    task automatic test_hex();
        send_conv(CH_X, 32'h0000_0000);
        send_conv(CH_X, 32'hffff_ffff);
        send_conv(CH_X, 32'h0000_abc0);
    endtask

    task automatic test_start_clears();
        // a new string drops the armed percent, so the d is echoed
        send_byte(CH_PERCENT, rand_arg(), 1'b0);
        send_byte(CH_D, rand_arg(), 1'b1);
    endtask

    task automatic test_random_strings();
        int target;
        int tokens;
        int kind;
        logic [7:0] conv;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            quiet = ($urandom_range(0, 99) < 20);
            tokens = $urandom_range(1, 12);
            send_byte(8'($urandom_range(0, 255)), rand_arg(), 1'b1);
            for (int t = 0; t < tokens; t++) begin
                kind = $urandom_range(0, 99);
                if (kind < 40) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: conv = CH_D;
                        4, 5, 6:    conv = CH_X;
                        7, 8:       conv = CH_PERCENT;
                        default:    conv = CH_S;
                    endcase
                    send_conv(conv, rand_arg());
                end else if (kind < 50) begin
                    // broken sequence, sometimes cut short by a new string
                    send_byte(CH_PERCENT, rand_arg(), 1'b0);
                    send_byte(8'($urandom_range(0, 255)), rand_arg(),
                              1'($urandom_range(0, 3) == 0));
                end else begin
                    send_byte(8'($urandom_range(0, 255)), rand_arg(), 1'b0);
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        pend_pct   = 1'b0;
        char_total = '0;
        mismatches = 0;
        bytes_sent = 0;
        chars_checked = 0;
        conversions = 0;
        quiet = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_echo();
        test_percent_forms();
        test_decimal();
        test_hex();
        test_start_clears();
        test_random_strings();

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            mismatches++;
            $display("%0d expected chars never arrived", expected_chars.size());
        end

        $display("tb_top: %0d format bytes sent, %0d d/x conversions, %0d chars checked",
                 bytes_sent, conversions, chars_checked);
        $display("tb_top: %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
